### rtl/core/swr_pkg.sv
// ----------------------------------------------------------------------------
// swr_pkg
// Shared types and constants for the stop-and-wait receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package swr_pkg;

   // result kinds (tuser)
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   // verdict codes
   localparam logic [1:0] VERDICT_ACCEPT  = 2'd0;
   localparam logic [1:0] VERDICT_REACK   = 2'd1;
   localparam logic [1:0] VERDICT_END     = 2'd2;
   localparam logic [1:0] VERDICT_DROPPED = 2'd3;

   // header kind bytes
   localparam logic [7:0] SIGN_DATA = 8'h00;
   localparam logic [7:0] SIGN_ACK  = 8'h02;
   localparam logic [7:0] SIGN_END  = 8'h07;

   // word positions in the datagram
   localparam int IDX_W = 11;
   localparam logic [IDX_W-1:0] IDX_LEN     = 11'd1;
   localparam logic [IDX_W-1:0] IDX_KIND    = 11'd2;
   localparam logic [IDX_W-1:0] IDX_PAYLOAD = 11'd3;
   localparam logic [IDX_W-1:0] IDX_MAX     = 11'd2047;

   localparam logic [15:0] SUM_GOOD = 16'hffff;

   // result queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   localparam int RSP_DATA_W = 136;

   typedef struct packed {
      logic        kind;
      logic        run_end;
      logic [15:0] payload_word;
      logic [31:0] payload_offset;
      logic [1:0]  verdict;
      logic        reply_valid;
      logic [15:0] reply_checksum;
      logic [15:0] reply_length;
      logic [7:0]  reply_sign;
      logic [7:0]  reply_seq;
      logic [31:0] total_bytes;
   } swr_result_type;

   // up to two results per word, payload first
   typedef struct packed {
      logic           first_valid;
      logic           second_valid;
      swr_result_type first;
      swr_result_type second;
   } swr_push_type;

   // 16-bit ones'-complement add with end-around carry
   function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      begin
         s = {1'b0, a} + {1'b0, b};
         oc_add = s[15:0] + {15'd0, s[16]};
      end
   endfunction

endpackage

`default_nettype wire

### rtl/core/swr_proc.sv
// ----------------------------------------------------------------------------
// swr_proc
// Per-word datagram processing: checksum, header capture, verdict, reply.
// ----------------------------------------------------------------------------
`default_nettype none

module swr_proc #(
   parameter int MAX_PAYLOAD_BYTES = 2048
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 fire,
   input  wire logic [15:0]          word,
   input  wire logic                 last,
   output swr_pkg::swr_push_type     push
);
   import swr_pkg::*;

   localparam logic [15:0] MaxLen  = 16'(MAX_PAYLOAD_BYTES);
   localparam logic [15:0] HalfMax = 16'(MAX_PAYLOAD_BYTES / 2);

   logic [7:0]       exp_seq_ff, exp_seq_in;
   logic [15:0]      sum_ff, sum_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [15:0]      hlen_ff, hlen_in;
   logic [7:0]       hkind_ff, hkind_in;
   logic [7:0]       hseq_ff, hseq_in;
   logic [31:0]      total_ff, total_in;
   logic             ovl_ff, ovl_in;

   logic [15:0]      sum_now;
   logic             ovl_now;
   logic [7:0]       hkind_now, hseq_now;
   logic [IDX_W-1:0] pw;
   logic [15:0]      words_in;
   logic             pay_valid;
   logic             bad, is_end, in_order;
   logic [15:0]      rep_len;
   logic [7:0]       rep_sign, rep_seq;
   logic [32:0]      total_sum;
   logic [31:0]      total_sat;
   swr_result_type   pay_r, ver_r;

   always_comb begin
      sum_now   = oc_add(sum_ff, word);
      hkind_now = (idx_ff == IDX_KIND) ? word[7:0]  : hkind_ff;
      hseq_now  = (idx_ff == IDX_KIND) ? word[15:8] : hseq_ff;
      pw        = idx_ff - IDX_PAYLOAD;
      // payload words so far including this one: idx - 2
      words_in  = 16'(idx_ff - IDX_KIND);

      ovl_now = ovl_ff;
      if (idx_ff == IDX_KIND && hlen_ff > MaxLen) begin
         ovl_now = 1'b1;
      end
      if (idx_ff >= IDX_PAYLOAD && (idx_ff == IDX_MAX || words_in > HalfMax)) begin
         ovl_now = 1'b1;
      end

      pay_valid = idx_ff >= IDX_PAYLOAD && !ovl_now && hkind_ff == SIGN_DATA;

      bad      = idx_ff < IDX_KIND || sum_now != SUM_GOOD || ovl_now;
      is_end   = hkind_now == SIGN_END;
      in_order = hseq_now == exp_seq_ff;

      // one reply header checksum; ACKs carry the expected number either way
      rep_len  = is_end ? hlen_ff : 16'd0;
      rep_sign = is_end ? SIGN_END : SIGN_ACK;
      rep_seq  = is_end ? hseq_now : exp_seq_ff;

      total_sum = {1'b0, total_ff} + {16'd0, hlen_ff};
      total_sat = total_sum[32] ? 32'hffff_ffff : total_sum[31:0];

      pay_r                = '0;
      pay_r.kind           = KIND_PAYLOAD;
      pay_r.payload_word   = word;
      pay_r.payload_offset = total_ff + {20'd0, pw, 1'b0};
      pay_r.run_end        = !last;

      ver_r         = '0;
      ver_r.kind    = KIND_VERDICT;
      ver_r.run_end = 1'b1;
      if (bad || (hkind_now != SIGN_DATA && !is_end)) begin
         ver_r.verdict = VERDICT_DROPPED;
      end else begin
         ver_r.reply_valid    = 1'b1;
         ver_r.reply_checksum = ~oc_add(rep_len, {rep_seq, rep_sign});
         ver_r.reply_length   = rep_len;
         ver_r.reply_sign     = rep_sign;
         ver_r.reply_seq      = rep_seq;
         if (is_end) begin
            ver_r.verdict     = VERDICT_END;
            ver_r.total_bytes = total_ff;
         end else if (in_order) begin
            ver_r.verdict = VERDICT_ACCEPT;
         end else begin
            ver_r.verdict = VERDICT_REACK;
         end
      end

      push.first_valid  = fire && (pay_valid || last);
      push.second_valid = fire && pay_valid && last;
      push.first        = pay_valid ? pay_r : ver_r;
      push.second       = ver_r;

      // next state
      exp_seq_in = exp_seq_ff;
      total_in   = total_ff;
      sum_in     = sum_now;
      idx_in     = (idx_ff == IDX_MAX) ? idx_ff : idx_ff + 1'b1;
      hlen_in    = (idx_ff == IDX_LEN) ? word : hlen_ff;
      hkind_in   = hkind_now;
      hseq_in    = hseq_now;
      ovl_in     = ovl_now;
      if (last) begin
         if (ver_r.verdict == VERDICT_END) begin
            exp_seq_in = '0;
            total_in   = '0;
         end else if (ver_r.verdict == VERDICT_ACCEPT) begin
            exp_seq_in = exp_seq_ff + 1'b1;
            total_in   = total_sat;
         end
         sum_in   = '0;
         idx_in   = '0;
         hlen_in  = '0;
         hkind_in = '0;
         hseq_in  = '0;
         ovl_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_seq_ff <= '0;
         sum_ff     <= '0;
         idx_ff     <= '0;
         hlen_ff    <= '0;
         hkind_ff   <= '0;
         hseq_ff    <= '0;
         total_ff   <= '0;
         ovl_ff     <= 1'b0;
      end else if (fire) begin
         exp_seq_ff <= exp_seq_in;
         sum_ff     <= sum_in;
         idx_ff     <= idx_in;
         hlen_ff    <= hlen_in;
         hkind_ff   <= hkind_in;
         hseq_ff    <= hseq_in;
         total_ff   <= total_in;
         ovl_ff     <= ovl_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/swr_queue.sv
// ----------------------------------------------------------------------------
// swr_queue
// Result queue: takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
`default_nettype none

module swr_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire swr_pkg::swr_push_type  push,
   output logic                        room,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output swr_pkg::swr_result_type     out_data
);
   import swr_pkg::*;

   swr_result_type    mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in;
   logic [QPTR_W-1:0] rd_ff, rd_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              pop;
   logic [QCNT_W-1:0] push_n;

   assign room      = cnt_ff <= QCNT_W'(QUEUE_DEPTH - 2);
   assign out_valid = cnt_ff != '0;
   assign out_data  = mem_ff[rd_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      push_n = QCNT_W'(push.first_valid) + QCNT_W'(push.second_valid);
      wr_in  = wr_ff + QPTR_W'(push_n);
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + push_n - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.first_valid) begin
         mem_ff[wr_ff] <= push.first;
      end
      if (push.second_valid) begin
         mem_ff[wr_ff + 1'b1] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("result queue over capacity");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push.first_valid |-> room)
      else $error("push without room");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      (pop && !push.first_valid) |=> cnt_ff == $past(cnt_ff) - 1'b1)
      else $error("pop did not drain queue");

endmodule

`default_nettype wire

### rtl/core/stop_and_wait_receiver.sv
// ----------------------------------------------------------------------------
// stop_and_wait_receiver
// Receive side of a stop-and-wait ARQ link with Internet checksum.
// ----------------------------------------------------------------------------
// Datagram words enter on req_ (16-bit words, tlast on the final one) and
// are taken one per cycle while the queue has room. Each word is registered,
// then processed in a single pass that updates the ones'-complement sum
// and header state and pushes its results into a four-entry result queue
// feeding rsp_. Payload words come out tentatively (tuser 0) with their
// byte offset; the last word of a datagram yields a verdict (tuser 1) with
// the ACK or END reply header. A result passes through the input register
// and the result queue. Sustained rate is one word per cycle while each
// word gives at most one result and rsp_tready stays high; the last word
// of a data packet whose tail is a payload word gives two results, so the
// single-result output port sets the pace there. Bad, over-long and
// unknown-kind packets give a dropped verdict with no reply.
// ----------------------------------------------------------------------------
`default_nettype none

module stop_and_wait_receiver #(
   parameter int MAX_PAYLOAD_BYTES = 2048
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // input words
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [15:0]                      req_tdata,   // [15:0] word
   input  wire logic                             req_tlast,   // last word of datagram
   // results
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // [15:0] payload_word, [47:16] payload_offset, [49:48] verdict,
   // [50] reply_valid, [66:51] reply_checksum, [82:67] reply_length,
   // [90:83] reply_sign, [98:91] reply_seq, [130:99] total_bytes, rest 0
   output logic [swr_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic                                  rsp_tuser,   // kind: 0 payload, 1 verdict
   output logic                                  rsp_tlast    // last result of this word
);
   import swr_pkg::*;

   // input register
   logic        in_valid_ff;
   logic [15:0] in_word_ff;
   logic        in_last_ff;

   logic           fire;
   logic           room;
   swr_push_type   push;
   swr_result_type rsp;

   // a registered word is processed as soon as the queue can hold two results
   assign fire       = in_valid_ff && room;
   assign req_tready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_word_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   swr_proc #(
      .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
   ) u_proc (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .word  (in_word_ff),
      .last  (in_last_ff),
      .push  (push)
   );

   swr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp)
   );

   assign rsp_tuser = rsp.kind;
   assign rsp_tlast = rsp.run_end;
   assign rsp_tdata = {5'd0, rsp.total_bytes, rsp.reply_seq, rsp.reply_sign,
                       rsp.reply_length, rsp.reply_checksum, rsp.reply_valid,
                       rsp.verdict, rsp.payload_offset, rsp.payload_word};

endmodule

`default_nettype wire
